>>> sv/ctlr_pkg.sv
package ctlr_pkg;

    // Fixed field widths of the result word.
    localparam int OUT_IDX_BITS = 3;
    localparam int COUNT_BITS   = 32;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MAPPING_MODE   = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_REPLACE_POLICY = 1'd1;

    typedef logic [CFG_DATA_BITS-1:0] mode_t;
    typedef logic [CFG_DATA_BITS-1:0] policy_t;

    localparam mode_t MODE_DIRECT  = 2'd0;
    localparam mode_t MODE_FULL    = 2'd1;
    localparam mode_t MODE_TWO_WAY = 2'd2;

    localparam policy_t POL_FIFO   = 2'd0;
    localparam policy_t POL_LRU    = 2'd1;
    localparam policy_t POL_RANDOM = 2'd2;

    // Random replacement source.
    localparam int LFSR_BITS = 16;
    localparam logic [LFSR_BITS-1:0] LFSR_SEED = 16'hACE1;

    // Bits consumed per cycle by the remainder unit.
    localparam int REM_DIGIT_BITS = 8;

    // Taps x^16 + x^14 + x^13 + x^11 + 1, shifting right.
    function automatic logic [LFSR_BITS-1:0] lfsr_step(input logic [LFSR_BITS-1:0] v);
        logic fb;
        fb = v[0] ^ v[2] ^ v[3] ^ v[5];
        return {fb, v[LFSR_BITS-1:1]};
    endfunction

    typedef struct packed {
        logic load;
        logic set_take;
        logic scan;
        logic rand_start;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic rem_busy;
        logic scan_last;
        logic need_rand;
        logic out_free;
    } sts_t;

endpackage

>>> sv/ctlr_ram.sv
module ctlr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/ctlr_rem.sv
module ctlr_rem #(
    parameter int DIVD_BITS = 16,
    parameter int REM_BITS  = 3
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [DIVD_BITS-1:0] dividend,
    input  logic [REM_BITS:0]    divisor,
    output logic                 busy,
    output logic [REM_BITS-1:0]  remainder
);
    import ctlr_pkg::*;

    localparam int STEPS    = DIVD_BITS / REM_DIGIT_BITS;
    localparam int CNT_BITS = $clog2(STEPS + 1);

    logic                 busy_reg;
    logic [CNT_BITS-1:0]  cnt_reg;
    logic [DIVD_BITS-1:0] shift_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [REM_BITS-1:0]  rem_next;
    logic [REM_BITS:0]    div_reg;

    // Restoring remainder, most significant bit first, one digit a cycle.
    always_comb begin
        logic [REM_BITS:0]   trial;
        logic [REM_BITS-1:0] part;
        part = rem_reg;
        for (int i = 0; i < REM_DIGIT_BITS; i++) begin
            trial = {part, shift_reg[DIVD_BITS-1-i]};
            if (trial >= div_reg) begin
                trial = trial - div_reg;
            end
            part = trial[REM_BITS-1:0];
        end
        rem_next = part;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(STEPS);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_BITS'(1);
            busy_reg <= (cnt_reg != CNT_BITS'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            shift_reg <= dividend;
            rem_reg   <= '0;
            div_reg   <= divisor;
        end else if (busy_reg) begin
            shift_reg <= shift_reg << REM_DIGIT_BITS;
            rem_reg   <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign remainder = rem_reg;

endmodule

>>> sv/ctlr_ctrl.sv
module ctlr_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  ctlr_pkg::sts_t sts,
    output ctlr_pkg::cmd_t cmd
);
    import ctlr_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SET    = 6'b000010,
        ST_SCAN   = 6'b000100,
        ST_DECIDE = 6'b001000,
        ST_RAND   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_SET;
                end
            end
            ST_SET: begin
                if (!sts.rem_busy) begin
                    cmd.set_take = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (sts.need_rand) begin
                    cmd.rand_start = 1'b1;
                    state_next     = ST_RAND;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_RAND: begin
                if (!sts.rem_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // The store is updated only when the result can be handed over.
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

>>> sv/ctlr_dp.sv
module ctlr_dp #(
    parameter int LINE_COUNT = 8,
    parameter int ADDR_BITS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ctlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ctlr_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic [ADDR_BITS-1:0]                s_address,
    input  ctlr_pkg::cmd_t                      cmd,
    output ctlr_pkg::sts_t                      sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [ctlr_pkg::OUT_IDX_BITS-1:0]   m_set_index,
    output logic [ctlr_pkg::OUT_IDX_BITS-1:0]   m_way,
    output logic [ctlr_pkg::COUNT_BITS-1:0]     m_hit_count,
    output logic [ctlr_pkg::COUNT_BITS-1:0]     m_miss_count
);
    import ctlr_pkg::*;

    localparam int LINE_BITS = $clog2(LINE_COUNT);
    localparam int DIV_BITS  = LINE_BITS + 1;
    localparam int DIVD_RAW  = (ADDR_BITS > LFSR_BITS) ? ADDR_BITS : LFSR_BITS;
    localparam int DIVD_BITS = ((DIVD_RAW + REM_DIGIT_BITS - 1) / REM_DIGIT_BITS)
                               * REM_DIGIT_BITS;
    localparam int EXT_BITS  = LINE_BITS + OUT_IDX_BITS;
    localparam int TF_BITS   = ADDR_BITS + STAMP_BITS;

    // Configuration.
    mode_t   mode_reg;
    policy_t policy_reg;

    // Item context.
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [STAMP_BITS-1:0] time_reg;
    logic [LFSR_BITS-1:0]  lfsr_reg;
    logic [LINE_BITS-1:0]  set_reg;
    logic [LINE_COUNT-1:0] valid_reg;
    logic [COUNT_BITS-1:0] hits_reg;
    logic [COUNT_BITS-1:0] misses_reg;

    // Scan pipeline and search results.
    logic                  issued_all_reg;
    logic [LINE_BITS-1:0]  issue_cnt_reg;
    logic                  eval_vld_reg;
    logic [LINE_BITS-1:0]  eval_way_reg;
    logic [LINE_BITS-1:0]  eval_line_reg;
    logic                  hit_found_reg;
    logic [LINE_BITS-1:0]  hit_way_reg;
    logic                  inv_found_reg;
    logic [LINE_BITS-1:0]  inv_way_reg;
    logic [STAMP_BITS-1:0] best_fill_reg;
    logic [LINE_BITS-1:0]  fill_way_reg;
    logic [STAMP_BITS-1:0] best_use_reg;
    logic [LINE_BITS-1:0]  use_way_reg;

    // Result word.
    logic                    m_valid_reg;
    logic                    m_hit_reg;
    logic [OUT_IDX_BITS-1:0] m_set_index_reg;
    logic [OUT_IDX_BITS-1:0] m_way_reg;
    logic [COUNT_BITS-1:0]   m_hit_count_reg;
    logic [COUNT_BITS-1:0]   m_miss_count_reg;

    logic [LINE_BITS-1:0]  base;
    logic [LINE_BITS-1:0]  ways_m1;
    logic [DIV_BITS-1:0]   set_div;
    logic [LINE_BITS-1:0]  issue_line;
    logic                  issue_en;
    logic [TF_BITS-1:0]    tf_rdata;
    logic [STAMP_BITS-1:0] use_rdata;
    logic [ADDR_BITS-1:0]  tag_q;
    logic [STAMP_BITS-1:0] fill_q;
    logic                  eval_first;
    logic [LINE_BITS-1:0]  victim;
    logic [LINE_BITS-1:0]  commit_line;
    logic [LFSR_BITS-1:0]  lfsr_next;
    logic                  rem_start;
    logic [DIVD_BITS-1:0]  rem_dividend;
    logic [DIV_BITS-1:0]   rem_divisor;
    logic                  rem_busy;
    logic [LINE_BITS-1:0]  rem_value;
    logic [COUNT_BITS-1:0] hits_next;
    logic [COUNT_BITS-1:0] misses_next;
    logic [EXT_BITS-1:0]   set_ext;
    logic [EXT_BITS-1:0]   way_ext;

    // Layout of the current mapping mode; an undefined mode maps directly.
    always_comb begin
        unique case (mode_reg)
            MODE_FULL: begin
                base    = '0;
                ways_m1 = LINE_BITS'(LINE_COUNT - 1);
                set_div = DIV_BITS'(1);
            end
            MODE_TWO_WAY: begin
                base    = LINE_BITS'({set_reg, 1'b0});
                ways_m1 = LINE_BITS'(1);
                set_div = DIV_BITS'(LINE_COUNT / 2);
            end
            default: begin
                base    = set_reg;
                ways_m1 = '0;
                set_div = DIV_BITS'(LINE_COUNT);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= MODE_DIRECT;
            policy_reg <= POL_FIFO;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_MAPPING_MODE:   mode_reg   <= cfg_wr_data;
                CFG_REPLACE_POLICY: policy_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Shared remainder unit: set number first, then the random way if needed.
    assign lfsr_next    = lfsr_step(lfsr_reg);
    assign rem_start    = cmd.load | cmd.rand_start;
    assign rem_dividend = cmd.rand_start ? DIVD_BITS'(lfsr_next) : DIVD_BITS'(s_address);
    assign rem_divisor  = cmd.rand_start ? (DIV_BITS'(ways_m1) + DIV_BITS'(1)) : set_div;

    ctlr_rem #(
        .DIVD_BITS(DIVD_BITS),
        .REM_BITS (LINE_BITS)
    ) u_rem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (rem_start),
        .dividend (rem_dividend),
        .divisor  (rem_divisor),
        .busy     (rem_busy),
        .remainder(rem_value)
    );

    // Tag and fill stamp share one memory; the use stamp has its own.
    assign issue_en   = cmd.scan && !issued_all_reg;
    assign issue_line = LINE_BITS'(base + issue_cnt_reg);

    always_comb begin
        if (hit_found_reg) begin
            victim = hit_way_reg;
        end else if (ways_m1 == '0) begin
            victim = '0;
        end else if (inv_found_reg) begin
            victim = inv_way_reg;
        end else begin
            unique case (policy_reg)
                POL_FIFO:   victim = fill_way_reg;
                POL_LRU:    victim = use_way_reg;
                POL_RANDOM: victim = rem_value;
                default:    victim = '0;
            endcase
        end
    end

    assign commit_line = LINE_BITS'(base + victim);

    ctlr_ram #(
        .WIDTH(TF_BITS),
        .DEPTH(LINE_COUNT)
    ) u_tag_ram (
        .aclk   (aclk),
        .wr_en  (cmd.commit && !hit_found_reg),
        .wr_addr(commit_line),
        .wr_data({addr_reg, time_reg}),
        .rd_addr(issue_line),
        .rd_data(tf_rdata)
    );

    ctlr_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(LINE_COUNT)
    ) u_use_ram (
        .aclk   (aclk),
        .wr_en  (cmd.commit),
        .wr_addr(commit_line),
        .wr_data(time_reg),
        .rd_addr(issue_line),
        .rd_data(use_rdata)
    );

    assign tag_q      = tf_rdata[TF_BITS-1:STAMP_BITS];
    assign fill_q     = tf_rdata[STAMP_BITS-1:0];
    assign eval_first = (eval_way_reg == '0);

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg       <= '0;
            lfsr_reg       <= LFSR_SEED;
            valid_reg      <= '0;
            hits_reg       <= '0;
            misses_reg     <= '0;
            issued_all_reg <= 1'b0;
            issue_cnt_reg  <= '0;
            eval_vld_reg   <= 1'b0;
            hit_found_reg  <= 1'b0;
            inv_found_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.load) begin
                time_reg <= time_reg + STAMP_BITS'(1);
            end
            if (cmd.rand_start) begin
                lfsr_reg <= lfsr_next;
            end
            if (cmd.set_take) begin
                issued_all_reg <= 1'b0;
                issue_cnt_reg  <= '0;
                eval_vld_reg   <= 1'b0;
                hit_found_reg  <= 1'b0;
                inv_found_reg  <= 1'b0;
            end else begin
                eval_vld_reg <= issue_en;
                if (issue_en) begin
                    if (issue_cnt_reg == ways_m1) begin
                        issued_all_reg <= 1'b1;
                    end else begin
                        issue_cnt_reg <= issue_cnt_reg + LINE_BITS'(1);
                    end
                end
                if (eval_vld_reg) begin
                    // The lowest way wins among duplicate tags and invalid lines.
                    if (!hit_found_reg && valid_reg[eval_line_reg] && tag_q == addr_reg) begin
                        hit_found_reg <= 1'b1;
                    end
                    if (!inv_found_reg && !valid_reg[eval_line_reg]) begin
                        inv_found_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit) begin
                if (hit_found_reg) begin
                    hits_reg <= hits_next;
                end else begin
                    misses_reg             <= misses_next;
                    valid_reg[commit_line] <= 1'b1;
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            addr_reg <= s_address;
        end
        if (cmd.set_take) begin
            set_reg <= rem_value;
        end
        eval_way_reg  <= issue_cnt_reg;
        eval_line_reg <= issue_line;
        if (eval_vld_reg) begin
            if (!hit_found_reg) begin
                hit_way_reg <= eval_way_reg;
            end
            if (!inv_found_reg) begin
                inv_way_reg <= eval_way_reg;
            end
            // Strict compare keeps the lowest way on equal stamps.
            if (eval_first || fill_q < best_fill_reg) begin
                best_fill_reg <= fill_q;
                fill_way_reg  <= eval_way_reg;
            end
            if (eval_first || use_rdata < best_use_reg) begin
                best_use_reg <= use_rdata;
                use_way_reg  <= eval_way_reg;
            end
        end
        if (cmd.commit) begin
            m_hit_reg        <= hit_found_reg;
            m_set_index_reg  <= set_ext[OUT_IDX_BITS-1:0];
            m_way_reg        <= way_ext[OUT_IDX_BITS-1:0];
            m_hit_count_reg  <= hit_found_reg ? hits_next : hits_reg;
            m_miss_count_reg <= hit_found_reg ? misses_reg : misses_next;
        end
    end

    assign hits_next   = (hits_reg == COUNT_MAX) ? hits_reg : hits_reg + COUNT_BITS'(1);
    assign misses_next = (misses_reg == COUNT_MAX) ? misses_reg
                                                   : misses_reg + COUNT_BITS'(1);
    assign set_ext     = EXT_BITS'(set_reg);
    assign way_ext     = EXT_BITS'(victim);

    assign sts.rem_busy  = rem_busy;
    assign sts.scan_last = eval_vld_reg && (eval_way_reg == ways_m1);
    assign sts.need_rand = !hit_found_reg && (ways_m1 != '0) && !inv_found_reg
                           && (policy_reg == POL_RANDOM);
    assign sts.out_free  = !m_valid_reg || m_ready;

    assign m_valid      = m_valid_reg;
    assign m_hit        = m_hit_reg;
    assign m_set_index  = m_set_index_reg;
    assign m_way        = m_way_reg;
    assign m_hit_count  = m_hit_count_reg;
    assign m_miss_count = m_miss_count_reg;

endmodule

>>> sv/cache_tag_lookup_replace.sv
// Flow: the accepted address goes to the shared remainder unit, which divides in S =
// ceil(max(ADDR_BITS,16)/8) digit steps, for its set number; the tag scan then reads one
// way per cycle over the W ways of the mapping mode (1, 2 or LINE_COUNT), and a random
// eviction of a valid line uses the remainder unit again. One word is handled at a time.
// Reset (aresetn, synchronous, active low) invalidates all lines, clears the clock
// and counters, seeds the LFSR and selects direct mapping with FIFO replacement.
module cache_tag_lookup_replace #(
    parameter int LINE_COUNT = 8,
    parameter int ADDR_BITS  = 16,
    parameter int STAMP_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [ctlr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ctlr_pkg::CFG_DATA_BITS-1:0]  cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ADDR_BITS-1:0]                s_address,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [ctlr_pkg::OUT_IDX_BITS-1:0]   m_set_index,
    output logic [ctlr_pkg::OUT_IDX_BITS-1:0]   m_way,
    output logic [ctlr_pkg::COUNT_BITS-1:0]     m_hit_count,
    output logic [ctlr_pkg::COUNT_BITS-1:0]     m_miss_count
);
    import ctlr_pkg::*;

    cmd_t cmd;
    sts_t sts;

    ctlr_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .sts    (sts),
        .cmd    (cmd)
    );

    ctlr_dp #(
        .LINE_COUNT(LINE_COUNT),
        .ADDR_BITS (ADDR_BITS),
        .STAMP_BITS(STAMP_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .s_address   (s_address),
        .cmd         (cmd),
        .sts         (sts),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_hit       (m_hit),
        .m_set_index (m_set_index),
        .m_way       (m_way),
        .m_hit_count (m_hit_count),
        .m_miss_count(m_miss_count)
    );

endmodule

>>> sv/ctlr_checker.sv
module ctlr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_hit,
    input logic [ctlr_pkg::OUT_IDX_BITS-1:0] m_set_index,
    input logic [ctlr_pkg::OUT_IDX_BITS-1:0] m_way,
    input logic [ctlr_pkg::COUNT_BITS-1:0]   m_hit_count,
    input logic [ctlr_pkg::COUNT_BITS-1:0]   m_miss_count
);

    // A result word waiting for the sink holds still.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_way)
                                && $stable(m_set_index) && $stable(m_hit_count)
                                && $stable(m_miss_count))
        else $error("result word changed while stalled");

    // One word at a time: the input side closes right after a word is taken.
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second word accepted during a lookup");

    // The counter matching the outcome already includes this access.
    a_hit_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_hit |-> m_hit_count != '0)
        else $error("hit reported with zero hit count");

    a_miss_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> m_miss_count != '0)
        else $error("miss reported with zero miss count");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

endmodule

bind cache_tag_lookup_replace ctlr_checker u_ctlr_checker (.*);
